>>> hdl/cbp_pkg.sv
package cbp_pkg;

    // Codeword width range and the number of bits that may be left over.
    localparam int MAX_CODE_WIDTH = 16;
    localparam int MIN_CODE_WIDTH = 9;
    localparam int CFG_W          = 5;
    localparam int PEND_W         = 7;
    localparam int PCNT_W         = 3;

    // Accumulator holds the leftover bits followed by one codeword.
    localparam int ACC_W     = MAX_CODE_WIDTH + PEND_W;
    localparam int MAX_BYTES = (ACC_W + 7) / 8;
    localparam int ALIGN_W   = MAX_BYTES * 8;
    localparam int TOTAL_W   = $clog2(ALIGN_W + 1);
    localparam int NCNT_W    = $clog2(MAX_BYTES + 1);
    localparam int SEL_W     = $clog2(MAX_BYTES);

    // Queue between the front and the back; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] CODE_WIDTH_RESET = CFG_W'(MIN_CODE_WIDTH);

    // One classified codeword: its bytes in stream order and how many are used.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [NCNT_W-1:0]         n_bytes;
        logic                      last;
    } t_cbp_entry;

    // Queue status seen by the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } t_cbp_qstat;

endpackage

>>> hdl/codeword_bit_packer.sv
// Packs codewords of 9 to 16 bits into a byte stream, most significant bit
// first, with no gaps between codewords.
// Input stream: s_axis_tdata carries the codeword, of which only the low
// code_width bits are used; s_axis_tlast marks the final codeword of a stream.
// Output stream: m_axis_tdata carries one packed byte, earliest bit in bit 7;
// m_axis_tlast marks the final byte. On a final codeword any partial byte is
// flushed with zero padding in its low bits.
// Configuration: a beat on i_cfg_valid writes code_width (5 bits) and is
// always taken; write it only between streams or while the block is idle.
// The first byte of a codeword passes through the queue and then the output
// register before it reaches the output port. Each codeword gives one to three
// bytes, at most two unless it closes a stream, and the back end sends one byte
// per cycle while m_axis_tready is high; a two-entry queue lets the input side
// keep accepting while the back end drains.
// Reset clears the leftover bits, the queue and the output register and sets
// code_width to 9. A stall on m_axis_tready holds the output beat, fills the
// queue and then drops s_axis_tready; no data is lost.
module codeword_bit_packer
    import cbp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_W-1:0]          i_cfg_data,     // code_width
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [MAX_CODE_WIDTH-1:0] s_axis_tdata,   // codeword
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // out_byte
    output logic                      m_axis_tlast
);

    logic [CFG_W-1:0]  r_code_width;
    logic              push;
    logic              pop;
    logic              q_valid;
    t_cbp_entry        push_entry;
    t_cbp_entry        head_entry;
    t_cbp_qstat        q_stat;
    logic [PCNT_W-1:0] pend_cnt;

    // Configuration register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_width <= CODE_WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_code_width <= i_cfg_data;
        end
    end

    cbp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_code_width (r_code_width),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_codeword   (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_q_full     (q_stat.full),
        .o_push       (push),
        .o_entry      (push_entry),
        .o_pend_cnt   (pend_cnt)
    );

    cbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (head_entry),
        .o_stat  (q_stat)
    );

    cbp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_entry   (head_entry),
        .o_pop     (pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast)
    );

    // A closing codeword leaves nothing pending for the next stream.
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (pend_cnt == '0))
        else $error("leftover bits survived the end of a stream");

    // The queue is never both full and empty, and is never popped when empty.
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty) && !(pop && q_stat.empty))
        else $error("queue status inconsistent");

    // Every queued codeword yields at least one and at most MAX_BYTES bytes.
    a_entry_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> (head_entry.n_bytes != '0) &&
                    (head_entry.n_bytes <= NCNT_W'(MAX_BYTES)))
        else $error("queued entry has an impossible byte count");

    // An input beat is refused only while the queue is full.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && !s_axis_tready) |-> q_stat.full)
        else $error("input stalled with room in the queue");

endmodule

>>> hdl/cbp_front.sv
module cbp_front
    import cbp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [CFG_W-1:0]          i_code_width,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [MAX_CODE_WIDTH-1:0] i_codeword,
    input  logic                      i_last,
    input  logic                      i_q_full,
    output logic                      o_push,
    output t_cbp_entry                o_entry,
    output logic [PCNT_W-1:0]         o_pend_cnt
);

    logic [PEND_W-1:0]         r_pend_bits;
    logic [PCNT_W-1:0]         r_pend_cnt;
    logic [PEND_W-1:0]         n_pend_bits;
    logic [PCNT_W-1:0]         n_pend_cnt;
    logic [CFG_W-1:0]          width;
    logic [MAX_CODE_WIDTH-1:0] code_mask;
    logic [ACC_W-1:0]          acc;
    logic [TOTAL_W-1:0]        total;
    logic [TOTAL_W-1:0]        shift;
    logic [ALIGN_W-1:0]        aligned;
    logic [PCNT_W-1:0]         rem;
    logic [NCNT_W-1:0]         n_full;
    logic                      accept;

    // Clamp the configured width into the supported range.
    always_comb begin
        if (i_code_width < CFG_W'(MIN_CODE_WIDTH)) begin
            width = CFG_W'(MIN_CODE_WIDTH);
        end else if (i_code_width > CFG_W'(MAX_CODE_WIDTH)) begin
            width = CFG_W'(MAX_CODE_WIDTH);
        end else begin
            width = i_code_width;
        end
    end

    // Append the codeword to the leftover bits and left-align the result.
    always_comb begin
        code_mask = ~({MAX_CODE_WIDTH{1'b1}} << width);
        acc       = (ACC_W'(r_pend_bits) << width) | ACC_W'(i_codeword & code_mask);
        total     = TOTAL_W'(r_pend_cnt) + TOTAL_W'(width);
        shift     = TOTAL_W'(ALIGN_W) - total;
        aligned   = ALIGN_W'(acc) << shift;
        rem       = total[PCNT_W-1:0];
        n_full    = NCNT_W'(total >> 3);
    end

    // Split into bytes; a flush keeps the zero padding below the last bits.
    always_comb begin
        for (int k = 0; k < MAX_BYTES; k++) begin
            o_entry.bytes[k] = aligned[ALIGN_W-1-8*k -: 8];
        end
        o_entry.n_bytes = n_full + NCNT_W'(i_last && (rem != '0));
        o_entry.last    = i_last;
    end

    assign o_ready    = !i_q_full;
    assign accept     = i_valid && !i_q_full;
    assign o_push     = accept;
    assign o_pend_cnt = r_pend_cnt;

    // Leftover bits carry over, and are dropped at the end of a stream.
    always_comb begin
        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        if (accept) begin
            if (i_last) begin
                n_pend_bits = '0;
                n_pend_cnt  = '0;
            end else begin
                n_pend_bits = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
                n_pend_cnt  = rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else begin
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

endmodule

>>> hdl/cbp_queue.sv
module cbp_queue
    import cbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cbp_entry i_entry,
    input  logic       i_pop,
    output logic       o_valid,
    output t_cbp_entry o_entry,
    output t_cbp_qstat o_stat
);

    t_cbp_entry        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_valid      = !o_stat.empty;
    assign o_entry      = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

>>> hdl/cbp_back.sv
module cbp_back
    import cbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cbp_entry i_entry,
    output logic       o_pop,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic       o_tlast
);

    logic             r_tvalid;
    logic [7:0]       r_tdata;
    logic             r_tlast;
    logic [SEL_W-1:0] r_sel;
    logic             n_tvalid;
    logic [SEL_W-1:0] n_sel;
    logic             load;
    logic             final_byte;

    // The output register takes a new beat when empty or being drained.
    assign load       = !r_tvalid || i_tready;
    assign final_byte = (NCNT_W'(r_sel) == i_entry.n_bytes - 1'b1);
    assign o_pop      = load && i_q_valid && final_byte;

    always_comb begin
        n_tvalid = r_tvalid;
        n_sel    = r_sel;
        if (load) begin
            n_tvalid = i_q_valid;
            if (i_q_valid) begin
                n_sel = final_byte ? '0 : r_sel + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
            r_sel    <= '0;
        end else begin
            r_tvalid <= n_tvalid;
            r_sel    <= n_sel;
        end
    end

    // Output payload; only the final byte of a closing codeword is marked.
    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_tdata <= i_entry.bytes[r_sel];
            r_tlast <= i_entry.last && final_byte;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

endmodule

>>> tb/tb_codeword_bit_packer.sv
module tb_codeword_bit_packer
    import cbp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 10;
    localparam int SETTLE_GAP   = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 280;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_W-1:0]          i_cfg_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [MAX_CODE_WIDTH-1:0] s_axis_tdata = '0;   // codeword
    logic                      s_axis_tlast = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [7:0]                m_axis_tdata;        // out_byte
    logic                      m_axis_tlast;

    // One packed byte as it should leave the block.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_packed_byte;

    // Tracks the leftover bits and the width register, and keeps the bytes that
    // each accepted codeword must produce, oldest first.
    class t_byte_scoreboard;
        logic [CFG_W-1:0] width_reg;
        logic [6:0]       leftover_bits;
        int unsigned      leftover_count;
        t_packed_byte     expected_bytes[$];
        int unsigned      errors;

        function void clear();
            width_reg      = CODE_WIDTH_RESET;
            leftover_bits  = '0;
            leftover_count = 0;
            expected_bytes.delete();
            errors         = 0;
        endfunction

        function void set_width(logic [CFG_W-1:0] value);
            width_reg = value;
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        // Out-of-range widths are clamped to the supported range.
        function int unsigned code_bits();
            int unsigned w;
            w = width_reg;
            if (w < MIN_CODE_WIDTH)
                w = MIN_CODE_WIDTH;
            if (w > MAX_CODE_WIDTH)
                w = MAX_CODE_WIDTH;
            return w;
        endfunction

        function void note_codeword(logic [15:0] cw, logic is_last);
            int unsigned  w;
            int unsigned  total;
            logic [31:0]  acc;
            t_packed_byte pb;
            w     = code_bits();
            acc   = ({25'd0, leftover_bits} << w) | ({16'd0, cw} & ((32'd1 << w) - 32'd1));
            total = leftover_count + w;
            // Emit every completed byte, oldest bits first.
            while (total >= 8) begin
                total   = total - 8;
                pb.data = 8'(acc >> total);
                pb.last = 1'b0;
                expected_bytes.push_back(pb);
            end
            acc = acc & ((32'd1 << total) - 32'd1);
            if (is_last) begin
                // Flush a partial byte with zero padding, or mark the final full byte.
                if (total > 0) begin
                    pb.data = 8'(acc << (8 - total));
                    pb.last = 1'b1;
                    expected_bytes.push_back(pb);
                end else begin
                    expected_bytes[expected_bytes.size() - 1].last = 1'b1;
                end
                leftover_bits  = '0;
                leftover_count = 0;
            end else begin
                leftover_bits  = 7'(acc);
                leftover_count = total;
            end
        endfunction

        function void check_byte(logic [7:0] data, logic is_last);
            t_packed_byte want;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual data %02h last %0b",
                         $realtime, data, is_last);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (data !== want.data) begin
                    $display("%0t: byte mismatch: expected %02h, actual %02h",
                             $realtime, want.data, data);
                    errors++;
                end
                if (is_last !== want.last) begin
                    $display("%0t: last flag mismatch: expected %0b, actual %0b",
                             $realtime, want.last, is_last);
                    errors++;
                end
            end
        endfunction
    endclass

    t_byte_scoreboard sb;
    int unsigned      cycle_count = 0;
    int unsigned      burst_left = 0;
    int unsigned      ready_mode = 0;
    int unsigned      ready_phase = 0;
    int unsigned      items_sent = 0;

    codeword_bit_packer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL codeword_bit_packer");
            $finish;
        end
    end

    // Watch all three channels at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_width(i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_codeword(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_byte(m_axis_tdata, m_axis_tlast);
        end
    end

    // Receiver back-pressure: a new pattern is picked at random whenever ready_phase wraps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (ready_phase == 63)
                ready_mode <= $urandom_range(0, 3);
            ready_phase <= (ready_phase + 1) % 64;
            case (ready_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ((ready_phase % 5) < 2);
            endcase
        end
    end

    // Present one codeword and hold it until the block takes the beat; bursts
    // end with a random gap of idle cycles.
    task automatic send_codeword(input logic [15:0] cw, input logic is_last);
        int unsigned gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cw;
        s_axis_tlast  <= is_last;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        items_sent++;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    // Stop sending and wait for every expected byte, then let the block settle.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0: return CFG_W'(MIN_CODE_WIDTH);
            1: return CFG_W'(MAX_CODE_WIDTH);
            2: return CFG_W'($urandom_range(0, MIN_CODE_WIDTH - 1));
            3: return CFG_W'($urandom_range(MAX_CODE_WIDTH + 1, 31));
            default: return CFG_W'($urandom_range(MIN_CODE_WIDTH, MAX_CODE_WIDTH));
        endcase
    endfunction

    function automatic logic [15:0] pick_codeword();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        int unsigned stream_len;
        int unsigned streams;
        sb = new();
        sb.clear();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = $urandom_range(1, 6);

        // Reset width of nine bits, stream ends with a padded partial byte.
        send_codeword(16'hFFFF, 1'b0);
        send_codeword(16'h0000, 1'b0);
        send_codeword(16'hAAAA, 1'b0);
        send_codeword(16'h5555, 1'b1);
        wait_drained();

        // Widest codes; a single final codeword ends on a byte boundary.
        write_width(CFG_W'(MAX_CODE_WIDTH));
        send_codeword(16'hFFFF, 1'b1);
        send_codeword(16'h0000, 1'b1);
        send_codeword(16'h8001, 1'b0);
        send_codeword(16'h7FFE, 1'b1);
        wait_drained();

        // Width below the range acts as nine; eight codes end on a boundary.
        write_width('0);
        for (int i = 0; i < 8; i++)
            send_codeword(16'h1234 + 16'(i * 16'h2F1), i == 7);
        wait_drained();

        // Width above the range acts as sixteen.
        write_width('1);
        send_codeword(16'hFFFF, 1'b0);
        send_codeword(16'h0001, 1'b1);
        wait_drained();

        // Width changed in the middle of a stream keeps the leftover bits.
        write_width(CFG_W'(13));
        send_codeword(16'h1ABC, 1'b0);
        wait_drained();
        write_width(CFG_W'(11));
        send_codeword(16'h07F3, 1'b0);
        send_codeword(16'h0555, 1'b1);
        wait_drained();

        // Random phases: a width, then a few well-formed streams of random codes.
        while (items_sent < RANDOM_ITEMS) begin
            write_width(pick_width());
            streams = $urandom_range(1, 4);
            for (int s = 0; s < streams; s++) begin
                stream_len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 30)
                                                         : $urandom_range(1, 8);
                for (int k = 0; k < stream_len; k++) begin
                    // Now and then pause mid-stream and maybe change the width.
                    if (k != 0 && $urandom_range(0, 19) == 0) begin
                        wait_drained();
                        if ($urandom_range(0, 1) == 1)
                            write_width(pick_width());
                    end
                    send_codeword(pick_codeword(), k == stream_len - 1);
                end
            end
            wait_drained();
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS codeword_bit_packer");
        end else begin
            $display("FAIL codeword_bit_packer");
        end
        $finish;
    end

endmodule
